>>> hdl/hmtq_pkg.sv
`timescale 1ns / 1ps

package hmtq_pkg;

  localparam int MAX_SIDE  = 128;
  localparam int FRAC      = 16;
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int CELL_W    = $clog2(MAX_SIDE);
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int BANK_AW   = IDX_W - 1;
  localparam int BANK_D    = DEPTH / 2;
  localparam int DATA_W    = 32;
  localparam int SPACE_W   = 16;
  localparam int MAG_W     = 32;
  localparam int POS_W     = MAG_W + 2;
  localparam int NLANE     = 6;
  localparam int NSAMP     = 5;
  localparam int TAG_W     = 3;
  localparam int ONE       = 1 << FRAC;
  localparam int OFFSET    = (3 * ONE + 5) / 10;
  localparam int DY        = 2 * OFFSET;
  localparam longint DY_SQ = longint'(DY) * longint'(DY);
  localparam int NRM_W     = 16;

  localparam logic signed [MAG_W:0] OFFSET_V = (MAG_W + 1)'(OFFSET);

  // lanes of the divider
  localparam int LN_X  = 0;
  localparam int LN_XM = 1;
  localparam int LN_XP = 2;
  localparam int LN_Z  = 3;
  localparam int LN_ZM = 4;
  localparam int LN_ZP = 5;

  // sample tags
  localparam logic [TAG_W-1:0] SMP_C = 3'd0;
  localparam logic [TAG_W-1:0] SMP_L = 3'd1;
  localparam logic [TAG_W-1:0] SMP_R = 3'd2;
  localparam logic [TAG_W-1:0] SMP_D = 3'd3;
  localparam logic [TAG_W-1:0] SMP_U = 3'd4;
  localparam logic [TAG_W-1:0] SMP_END = 3'd5;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic CFG_SPACING = 1'b0;
  localparam logic CFG_SIDE    = 1'b1;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef pos_t [NLANE-1:0] pos_vec_t;

  typedef struct packed {
    pos_t             gx;
    pos_t             gz;
    logic [TAG_W-1:0] tag;
  } samp_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]           tag;
    logic                       oob;
    logic signed [DATA_W-1:0]   h;
  } samp_res_t;

  typedef struct packed {
    logic                     oob;
    logic signed [DATA_W-1:0] h0;
    logic signed [DATA_W-1:0] hl;
    logic signed [DATA_W-1:0] hr;
    logic signed [DATA_W-1:0] hd;
    logic signed [DATA_W-1:0] hu;
  } norm_in_t;

  typedef struct packed {
    logic                     oob;
    logic signed [DATA_W-1:0] height;
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic signed [NRM_W-1:0]  nz;
  } norm_res_t;

endpackage

>>> hdl/hmtq_grid_div.sv
`timescale 1ns / 1ps

module hmtq_grid_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [31:0]                coord_x_i,
  input  logic signed [31:0]                coord_z_i,
  input  logic [hmtq_pkg::SPACE_W-1:0]      spacing_i,
  input  hmtq_pkg::pos_t                    half_span_i,
  output logic                              ready_o,
  output logic                              done_o,
  input  logic                              take_i,
  output hmtq_pkg::pos_vec_t                pos_o
);
  import hmtq_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);
  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_FIX  = 2'd2;
  localparam logic [1:0] DV_DONE = 2'd3;

  logic [1:0]              state_q;
  logic [STEP_W-1:0]       step_q;
  logic [SPACE_W-1:0]      div_q;
  logic [MAG_W-1:0]        mag_q [NLANE];
  logic [MAG_W-1:0]        mag_d [NLANE];
  logic [SPACE_W-1:0]      rem_q [NLANE];
  logic [SPACE_W-1:0]      rem_d [NLANE];
  logic [NLANE-1:0]        neg_q;
  pos_vec_t                pos_q;

  logic signed [MAG_W:0]   init_v [NLANE];
  logic [MAG_W:0]          init_m [NLANE];
  logic [SPACE_W:0]        rs [NLANE];
  logic                    ge [NLANE];
  pos_t                    qf [NLANE];

  always_comb begin
    init_v[LN_X]  = {coord_x_i[31], coord_x_i};
    init_v[LN_XM] = init_v[LN_X] - OFFSET_V;
    init_v[LN_XP] = init_v[LN_X] + OFFSET_V;
    init_v[LN_Z]  = {coord_z_i[31], coord_z_i};
    init_v[LN_ZM] = init_v[LN_Z] - OFFSET_V;
    init_v[LN_ZP] = init_v[LN_Z] + OFFSET_V;
    for (int k = 0; k < NLANE; k++) begin
      init_m[k] = init_v[k][MAG_W] ? (~init_v[k] + 1'b1) : init_v[k];
    end
  end

  // one restoring step per lane and cycle, quotient bits shift in behind
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      rs[k]    = {rem_q[k], mag_q[k][MAG_W-1]};
      ge[k]    = rs[k] >= {1'b0, div_q};
      rem_d[k] = ge[k] ? SPACE_W'(rs[k] - {1'b0, div_q}) : rs[k][SPACE_W-1:0];
      mag_d[k] = {mag_q[k][MAG_W-2:0], ge[k]};
      // floor for negative dividends
      qf[k] = neg_q[k] ? -(POS_W'(mag_q[k]) + POS_W'(rem_q[k] != '0))
                       : POS_W'(mag_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            state_q <= DV_RUN;
            step_q  <= '0;
          end
        end
        DV_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(MAG_W - 1)) state_q <= DV_FIX;
        end
        DV_FIX:  state_q <= DV_DONE;
        DV_DONE: if (take_i) state_q <= DV_IDLE;
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      div_q <= (spacing_i == '0) ? SPACE_W'(1) : spacing_i;
      for (int k = 0; k < NLANE; k++) begin
        mag_q[k] <= init_m[k][MAG_W-1:0];
        rem_q[k] <= '0;
        neg_q[k] <= init_v[k][MAG_W];
      end
    end else if (state_q == DV_RUN) begin
      for (int k = 0; k < NLANE; k++) begin
        mag_q[k] <= mag_d[k];
        rem_q[k] <= rem_d[k];
      end
    end else if (state_q == DV_FIX) begin
      for (int k = 0; k < NLANE; k++) begin
        pos_q[k] <= qf[k] + half_span_i;
      end
    end
  end

  assign ready_o = (state_q == DV_IDLE);
  assign done_o  = (state_q == DV_DONE);
  assign pos_o   = pos_q;

endmodule

>>> hdl/hmtq_sampler.sv
`timescale 1ns / 1ps

module hmtq_sampler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [hmtq_pkg::IDX_W-1:0]         wr_idx_i,
  input  logic [hmtq_pkg::DATA_W-1:0]        wr_data_i,
  input  logic                               req_valid_i,
  input  hmtq_pkg::samp_req_t                req_i,
  input  logic [hmtq_pkg::SIDE_W-1:0]        side_i,
  output logic                               res_valid_o,
  output hmtq_pkg::samp_res_t                res_o
);
  import hmtq_pkg::*;

  localparam int W_W    = FRAC + 1;
  localparam int PROD_W = DATA_W + W_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int H_W    = SUM_W - FRAC;

  // four banks: row copy a/b, even/odd entry
  logic [DATA_W-1:0] bank_ae [BANK_D];
  logic [DATA_W-1:0] bank_ao [BANK_D];
  logic [DATA_W-1:0] bank_be [BANK_D];
  logic [DATA_W-1:0] bank_bo [BANK_D];

  // address stage
  pos_t               lim;
  logic               oob_c;
  logic [CELL_W-1:0]  x0, z0;
  logic [IDX_W-1:0]   a_c, b_c, a_inc, b_inc;

  logic               v0_q, oob0_q, a0_q, b0_q;
  logic [TAG_W-1:0]   tag0_q;
  logic [FRAC-1:0]    fx0_q, fz0_q;
  logic [BANK_AW-1:0] ae_q, ao_q, be_q, bo_q;

  // read stage
  logic               v1_q, oob1_q, a1_q, b1_q;
  logic [TAG_W-1:0]   tag1_q;
  logic [FRAC-1:0]    fx1_q, fz1_q;
  logic [DATA_W-1:0]  rd_ae_q, rd_ao_q, rd_be_q, rd_bo_q;

  // product stage
  logic [DATA_W-1:0]  f00, f10, f01, f11, fa, fb, fc;
  logic [W_W-1:0]     wa, wb, wc, fsum;
  logic               v2_q, oob2_q;
  logic [TAG_W-1:0]   tag2_q;
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q;

  // sum stage
  logic signed [SUM_W-1:0] acc;
  logic signed [H_W-1:0]   hs;
  logic signed [DATA_W-1:0] hsat;
  logic               v3_q;
  samp_res_t          res_q;

  always_comb begin
    lim   = POS_W'(side_i - 1'b1) << FRAC;
    oob_c = ($signed(req_i.gx) <= 0) || ($signed(req_i.gz) <= 0) ||
            ($signed(req_i.gx) >= lim) || ($signed(req_i.gz) >= lim);
    x0    = req_i.gx[FRAC +: CELL_W];
    z0    = req_i.gz[FRAC +: CELL_W];
    a_c   = IDX_W'(z0) * IDX_W'(side_i) + IDX_W'(x0);
    b_c   = a_c + IDX_W'(side_i);
    a_inc = a_c + IDX_W'(1);
    b_inc = b_c + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= req_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag0_q <= req_i.tag;
    oob0_q <= oob_c;
    fx0_q  <= req_i.gx[FRAC-1:0];
    fz0_q  <= req_i.gz[FRAC-1:0];
    a0_q   <= a_c[0];
    b0_q   <= b_c[0];
    ae_q   <= a_inc[IDX_W-1:1];
    ao_q   <= a_c[IDX_W-1:1];
    be_q   <= b_inc[IDX_W-1:1];
    bo_q   <= b_c[IDX_W-1:1];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_idx_i[0]) begin
      bank_ae[wr_idx_i[IDX_W-1:1]] <= wr_data_i;
    end
    rd_ae_q <= bank_ae[ae_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i[0]) begin
      bank_ao[wr_idx_i[IDX_W-1:1]] <= wr_data_i;
    end
    rd_ao_q <= bank_ao[ao_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_idx_i[0]) begin
      bank_be[wr_idx_i[IDX_W-1:1]] <= wr_data_i;
    end
    rd_be_q <= bank_be[be_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i[0]) begin
      bank_bo[wr_idx_i[IDX_W-1:1]] <= wr_data_i;
    end
    rd_bo_q <= bank_bo[bo_q];
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= tag0_q;
    oob1_q <= oob0_q;
    fx1_q  <= fx0_q;
    fz1_q  <= fz0_q;
    a1_q   <= a0_q;
    b1_q   <= b0_q;
  end

  always_comb begin
    f00  = a1_q ? rd_ao_q : rd_ae_q;
    f10  = a1_q ? rd_ae_q : rd_ao_q;
    f01  = b1_q ? rd_bo_q : rd_be_q;
    f11  = b1_q ? rd_be_q : rd_bo_q;
    fsum = W_W'(fx1_q) + W_W'(fz1_q);
    if (fsum <= W_W'(ONE)) begin
      // lower triangle
      fa = f00;
      wa = W_W'(ONE) - fsum;
      fb = f10;
      wb = W_W'(fx1_q);
      fc = f01;
      wc = W_W'(fz1_q);
    end else begin
      fa = f11;
      wa = fsum - W_W'(ONE);
      fb = f10;
      wb = W_W'(ONE) - W_W'(fz1_q);
      fc = f01;
      wc = W_W'(ONE) - W_W'(fx1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= tag1_q;
    oob2_q <= oob1_q;
    pa_q   <= PROD_W'($signed(fa) * $signed({1'b0, wa}));
    pb_q   <= PROD_W'($signed(fb) * $signed({1'b0, wb}));
    pc_q   <= PROD_W'($signed(fc) * $signed({1'b0, wc}));
  end

  always_comb begin
    acc = SUM_W'(pa_q) + SUM_W'(pb_q) + SUM_W'(pc_q) + SUM_W'(ONE / 2);
    hs  = H_W'(acc >>> FRAC);
    if (oob2_q) begin
      hsat = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (hs > H_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      hsat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (hs < -(H_W'(1) <<< (DATA_W - 1))) begin
      hsat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      hsat = hs[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.tag <= tag2_q;
    res_q.oob <= oob2_q;
    res_q.h   <= hsat;
  end

  assign res_valid_o = v3_q;
  assign res_o       = res_q;

endmodule

>>> hdl/hmtq_normal.sv
`timescale 1ns / 1ps

module hmtq_normal (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  hmtq_pkg::norm_in_t   in_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 take_i,
  output hmtq_pkg::norm_res_t  res_o
);
  import hmtq_pkg::*;

  localparam int SQ_W   = 2 * MAG_W;
  localparam int ROOT_N = SQ_W / 2;
  localparam int CNT_W  = $clog2(ROOT_N);
  localparam int NUM_W  = MAG_W + NRM_W;
  localparam int NCOMP  = 3;

  localparam logic [2:0] NM_IDLE = 3'd0;
  localparam logic [2:0] NM_SQX  = 3'd1;
  localparam logic [2:0] NM_SQZ  = 3'd2;
  localparam logic [2:0] NM_ACC  = 3'd3;
  localparam logic [2:0] NM_ROOT = 3'd4;
  localparam logic [2:0] NM_DINI = 3'd5;
  localparam logic [2:0] NM_DIV  = 3'd6;
  localparam logic [2:0] NM_DONE = 3'd7;

  logic [2:0]               state_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     oob_q;
  logic signed [DATA_W-1:0] h0_q, dx_q, dz_q;
  logic [SQ_W-1:0]          p_q, acc_q, v_q, r_q, bit_q;
  logic [MAG_W-1:0]         len_q;
  logic [MAG_W-1:0]         rem_q [NCOMP];
  logic [NRM_W-1:0]         low_q [NCOMP];
  logic [NCOMP-1:0]         neg_q;

  logic signed [DATA_W:0]   ex, ez;
  logic signed [DATA_W-1:0] dx_c, dz_c;
  logic [MAG_W-1:0]         mx, mz;
  logic [MAG_W-1:0]         cmag [NCOMP];
  logic [NUM_W-1:0]         num [NCOMP];
  logic [SQ_W-1:0]          trial;
  logic                     root_ge;
  logic [MAG_W:0]           rs [NCOMP];
  logic                     dge [NCOMP];
  logic signed [NRM_W-1:0]  comp [NCOMP];

  function automatic logic signed [DATA_W-1:0] sat_diff(logic signed [DATA_W:0] d);
    logic signed [DATA_W-1:0] r;
    if (d[DATA_W] != d[DATA_W-1]) begin
      r = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = d[DATA_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    ex   = {in_i.hl[DATA_W-1], in_i.hl} - {in_i.hr[DATA_W-1], in_i.hr};
    ez   = {in_i.hd[DATA_W-1], in_i.hd} - {in_i.hu[DATA_W-1], in_i.hu};
    dx_c = sat_diff(ex);
    dz_c = sat_diff(ez);
    mx   = dx_q[DATA_W-1] ? (~dx_q + 1'b1) : dx_q;
    mz   = dz_q[DATA_W-1] ? (~dz_q + 1'b1) : dz_q;
    cmag[0] = mx;
    cmag[1] = MAG_W'(DY);
    cmag[2] = mz;
    trial   = r_q + bit_q;
    root_ge = v_q >= trial;
    for (int k = 0; k < NCOMP; k++) begin
      // rounded numerator, its upper part is already below len
      num[k]  = {1'b0, cmag[k], {(NRM_W-1){1'b0}}} + NUM_W'(len_q[MAG_W-1:1]);
      rs[k]   = {rem_q[k], low_q[k][NRM_W-1]};
      dge[k]  = rs[k] >= {1'b0, len_q};
      if (neg_q[k]) begin
        comp[k] = -$signed(low_q[k]);
      end else if (low_q[k][NRM_W-1]) begin
        comp[k] = {1'b0, {(NRM_W-1){1'b1}}};
      end else begin
        comp[k] = low_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NM_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        NM_IDLE: if (start_i) state_q <= NM_SQX;
        NM_SQX:  state_q <= NM_SQZ;
        NM_SQZ:  state_q <= NM_ACC;
        NM_ACC: begin
          state_q <= NM_ROOT;
          cnt_q   <= '0;
        end
        NM_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_N - 1)) state_q <= NM_DINI;
        end
        NM_DINI: begin
          state_q <= NM_DIV;
          cnt_q   <= '0;
        end
        NM_DIV: begin
          // a load first, then one step per quotient bit
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NRM_W)) state_q <= NM_DONE;
        end
        NM_DONE: if (take_i) state_q <= NM_IDLE;
        default: state_q <= NM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      NM_IDLE: begin
        if (start_i) begin
          oob_q <= in_i.oob;
          h0_q  <= in_i.h0;
          dx_q  <= dx_c;
          dz_q  <= dz_c;
        end
      end
      NM_SQX: begin
        p_q   <= mx * mx;
        acc_q <= SQ_W'(DY_SQ);
      end
      NM_SQZ: begin
        acc_q <= acc_q + p_q;
        p_q   <= mz * mz;
      end
      NM_ACC: begin
        v_q   <= acc_q + p_q;
        r_q   <= '0;
        bit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      NM_ROOT: begin
        if (root_ge) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      NM_DINI: begin
        len_q <= r_q[MAG_W-1:0];
        neg_q <= {dz_q[DATA_W-1], 1'b0, dx_q[DATA_W-1]};
      end
      NM_DIV: begin
        for (int k = 0; k < NCOMP; k++) begin
          rem_q[k] <= dge[k] ? MAG_W'(rs[k] - {1'b0, len_q}) : rs[k][MAG_W-1:0];
          low_q[k] <= {low_q[k][NRM_W-2:0], dge[k]};
        end
      end
      NM_DONE: begin
      end
      default: begin
      end
    endcase
    // numerator split must see the new len, so load it in NM_DIV, the state after NM_DINI
    if (state_q == NM_DIV && cnt_q == '0) begin
      for (int k = 0; k < NCOMP; k++) begin
        rem_q[k] <= num[k][NUM_W-1:NRM_W];
        low_q[k] <= num[k][NRM_W-1:0];
      end
    end
  end

  assign ready_o    = (state_q == NM_IDLE);
  assign valid_o    = (state_q == NM_DONE) && (cnt_q == CNT_W'(NRM_W + 1));
  assign res_o.oob    = oob_q;
  assign res_o.height = h0_q;
  assign res_o.nx     = comp[0];
  assign res_o.ny     = comp[1];
  assign res_o.nz     = comp[2];

endmodule

>>> hdl/heightmap_triangle_height_query.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// input     in         in_valid_i / in_ready_o   action, coord_x/z, entry_index/height
// result    out        out_valid_o / out_ready_i out_of_bounds, surface_height, normal_x/y/z
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// a write beat is held back while the coordinate divider is busy or while a query
// ahead of it has still to read the height banks. a query beat runs through the
// six-lane coordinate divider, the corner reads and pipeline of the sampler, then
// the normal unit (32 square-root steps, a load and 16 divide steps); queries
// overlap across units, so the normal unit sets the sustained query rate. reset
// clears control only; the height banks hold nothing until written. a stalled
// result sits in the output register while the units behind it keep working.

module heightmap_triangle_height_query (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_z_i,
  input  logic [13:0]         entry_index_i,
  input  logic signed [31:0]  entry_height_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_of_bounds_o,
  output logic signed [31:0]  surface_height_o,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import hmtq_pkg::*;

  logic [SPACE_W-1:0] spacing_q;
  logic [7:0]         side_q;
  logic [SIDE_W-1:0]  side_eff;
  pos_t               half_span;

  logic               div_ready, div_done, div_take, div_start;
  pos_vec_t           pos;
  logic               wr_en;

  logic               samp_busy_q, h_full_q;
  logic [TAG_W-1:0]   issue_q, got_q;
  logic               issue;
  samp_req_t          req;
  logic               res_valid;
  samp_res_t          res;
  norm_in_t           hold_q;

  logic               norm_ready, norm_valid, norm_start, norm_take;
  norm_res_t          norm_res;
  logic               out_valid_q;
  norm_res_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACE_W'(1);
      side_q    <= 8'(MAX_SIDE);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPACING: spacing_q <= cfg_data_i;
        CFG_SIDE:    side_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_q < 8'd2) begin
      side_eff = SIDE_W'(2);
    end else if (side_q > 8'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(side_q);
    end
    half_span = POS_W'(side_eff - 1'b1) << (FRAC - 1);
  end

  // writes wait until every query ahead has read its corners
  assign in_ready_o = div_ready && (action_i == ACT_QUERY || !samp_busy_q);
  assign div_start  = in_valid_i && in_ready_o && action_i == ACT_QUERY;
  assign wr_en      = in_valid_i && in_ready_o && action_i == ACT_WRITE;

  hmtq_grid_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .coord_x_i   (coord_x_i),
    .coord_z_i   (coord_z_i),
    .spacing_i   (spacing_q),
    .half_span_i (half_span),
    .ready_o     (div_ready),
    .done_o      (div_done),
    .take_i      (div_take),
    .pos_o       (pos)
  );

  assign issue    = samp_busy_q && issue_q != SMP_END;
  assign div_take = issue && issue_q == SMP_U;

  always_comb begin
    req.tag = issue_q;
    req.gx  = pos[LN_X];
    req.gz  = pos[LN_Z];
    unique case (issue_q)
      SMP_L:   req.gx = pos[LN_XM];
      SMP_R:   req.gx = pos[LN_XP];
      SMP_D:   req.gz = pos[LN_ZM];
      SMP_U:   req.gz = pos[LN_ZP];
      default: ;
    endcase
  end

  hmtq_sampler u_samp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_idx_i    (entry_index_i),
    .wr_data_i   (entry_height_i),
    .req_valid_i (issue),
    .req_i       (req),
    .side_i      (side_eff),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign norm_start = h_full_q && norm_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_busy_q <= 1'b0;
      h_full_q    <= 1'b0;
      issue_q     <= '0;
      got_q       <= '0;
    end else begin
      if (!samp_busy_q && !h_full_q && div_done) begin
        samp_busy_q <= 1'b1;
        issue_q     <= SMP_C;
        got_q       <= '0;
      end else if (issue) begin
        issue_q <= issue_q + 1'b1;
      end
      if (res_valid) begin
        got_q <= got_q + 1'b1;
        if (got_q == SMP_U) begin
          samp_busy_q <= 1'b0;
          h_full_q    <= 1'b1;
        end
      end else if (norm_start) begin
        h_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      unique case (res.tag)
        SMP_C: begin
          hold_q.h0  <= res.h;
          hold_q.oob <= res.oob;
        end
        SMP_L:   hold_q.hl <= res.h;
        SMP_R:   hold_q.hr <= res.h;
        SMP_D:   hold_q.hd <= res.h;
        default: hold_q.hu <= res.h;
      endcase
    end
  end

  hmtq_normal u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .in_i    (hold_q),
    .ready_o (norm_ready),
    .valid_o (norm_valid),
    .take_i  (norm_take),
    .res_o   (norm_res)
  );

  assign norm_take = norm_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (norm_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (norm_take) out_q <= norm_res;
  end

  assign out_valid_o      = out_valid_q;
  assign out_of_bounds_o  = out_q.oob;
  assign surface_height_o = out_q.height;
  assign normal_x_o       = out_q.nx;
  assign normal_y_o       = out_q.ny;
  assign normal_z_o       = out_q.nz;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hmtq_pkg::*;

  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam longint ONE_L = longint'(ONE);
  localparam longint OFF_L = longint'(OFFSET);
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint I32_MAX = 64'sd2147483647;

  typedef struct {
    logic               act;
    logic signed [31:0] cx;
    logic signed [31:0] cz;
    logic [13:0]        idx;
    logic signed [31:0] hv;
  } beat_t;

  typedef struct {
    logic               oob;
    logic signed [31:0] h;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } surf_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_z_i;
  logic [13:0]        entry_index_i;
  logic signed [31:0] entry_height_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               out_of_bounds_o;
  logic signed [31:0] surface_height_o;
  logic signed [15:0] normal_x_o;
  logic signed [15:0] normal_y_o;
  logic signed [15:0] normal_z_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [15:0]        cfg_data_i;

  heightmap_triangle_height_query uut (.*);

  beat_t              beat_q[$];
  surf_t              surf_q[$];
  logic signed [31:0] height_mem [DEPTH];
  bit                 written [DEPTH];
  logic [15:0]        spacing_reg;
  logic [7:0]         side_reg;
  int                 errors;
  int                 items;
  longint             cycles;
  bit                 calm;
  bit                 in_taken;
  int                 gap;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- surface predictor ----------------
  function automatic longint n_side();
    longint n;
    n = longint'(side_reg);
    if (n < 2) n = 2;
    if (n > MAX_SIDE) n = MAX_SIDE;
    return n;
  endfunction

  function automatic longint fdiv(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint sat32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint grid_of(longint c);
    longint d;
    d = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
    return fdiv(c, d) + ((n_side() - 1) <<< (FRAC - 1));
  endfunction

  function automatic bit on_grid(longint gx, longint gz);
    longint lim;
    lim = (n_side() - 1) <<< FRAC;
    return gx > 0 && gz > 0 && gx < lim && gz < lim;
  endfunction

  function automatic longint height_at(longint lx, longint lz, output bit oob);
    longint gx, gz, n, x0, z0, fx, fz, f00, f10, f01, f11, acc;
    gx = grid_of(lx);
    gz = grid_of(lz);
    n = n_side();
    oob = !on_grid(gx, gz);
    if (oob) return I32_MIN;
    x0 = gx >>> FRAC;
    z0 = gz >>> FRAC;
    fx = gx & (ONE_L - 1);
    fz = gz & (ONE_L - 1);
    f00 = height_mem[z0 * n + x0];
    f10 = height_mem[z0 * n + x0 + 1];
    f01 = height_mem[(z0 + 1) * n + x0];
    f11 = height_mem[(z0 + 1) * n + x0 + 1];
    if (fx + fz <= ONE_L)
      acc = f00 * (ONE_L - fx - fz) + f10 * fx + f01 * fz;
    else
      acc = f10 * (ONE_L - fz) + f11 * (fx + fz - ONE_L) + f01 * (ONE_L - fx);
    return sat32((acc + (ONE_L >>> 1)) >>> FRAC);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_unit(longint c, longint len);
    longint mag, q;
    mag = (c < 0) ? -c : c;
    q = (mag * 32768 + len / 2) / len;
    if (c < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic surf_t predict_surface(longint lx, longint lz);
    surf_t  r;
    bit     oob, dummy;
    longint h, hl, hr, hd, hu, dx, dy, dz, len;
    longint unsigned s;
    h  = height_at(lx, lz, oob);
    hl = height_at(lx - OFF_L, lz, dummy);
    hr = height_at(lx + OFF_L, lz, dummy);
    hd = height_at(lx, lz - OFF_L, dummy);
    hu = height_at(lx, lz + OFF_L, dummy);
    dx = sat32(hl - hr);
    dy = 2 * OFF_L;
    dz = sat32(hd - hu);
    s = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    len = longint'(int_sqrt(s));
    if (len < 1) len = 1;
    r.oob = oob;
    r.h   = h[31:0];
    r.nx  = to_unit(dx, len);
    r.ny  = to_unit(dy, len);
    r.nz  = to_unit(dz, len);
    return r;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic signed [31:0] pick_height();
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) return $urandom;
    if (k < 35) return k[0] ? 32'sh7fffffff : 32'sh80000000;
    return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
  endfunction

  task automatic push_write(logic [13:0] idx, logic signed [31:0] hv);
    beat_t b;
    b.act = ACT_WRITE;
    b.cx  = $urandom;
    b.cz  = $urandom;
    b.idx = idx;
    b.hv  = hv;
    height_mem[idx] = hv;
    written[idx] = 1'b1;
    beat_q.push_back(b);
    items++;
  endtask

  // fill every never-written corner that one of the five samples will read
  task automatic fill_corners(longint lx, longint lz);
    longint sx, sz, gx, gz, n, base;
    n = n_side();
    for (int k = 0; k < NSAMP; k++) begin
      sx = lx + ((k == 1) ? -OFF_L : (k == 2) ? OFF_L : 0);
      sz = lz + ((k == 3) ? -OFF_L : (k == 4) ? OFF_L : 0);
      gx = grid_of(sx);
      gz = grid_of(sz);
      if (on_grid(gx, gz)) begin
        base = (gz >>> FRAC) * n + (gx >>> FRAC);
        for (int c = 0; c < 4; c++) begin
          if (!written[base + (c >> 1) * n + (c & 1)])
            push_write(14'(base + (c >> 1) * n + (c & 1)), pick_height());
        end
      end
    end
  endtask

  task automatic push_query(longint lx, longint lz);
    beat_t b;
    fill_corners(lx, lz);
    b.act = ACT_QUERY;
    b.cx  = lx[31:0];
    b.cz  = lz[31:0];
    b.idx = 14'($urandom);
    b.hv  = $urandom;
    beat_q.push_back(b);
    surf_q.push_back(predict_surface(lx, lz));
    items++;
  endtask

  function automatic longint pick_coord();
    longint n, lim, g, sp, c;
    int k;
    n = n_side();
    lim = (n - 1) <<< FRAC;
    sp = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
    k = $urandom_range(0, 99);
    if (k < 80) g = $urandom_range(1, int'(lim - 1));
    else g = ((k < 90) ? 0 : lim) + $urandom_range(0, 2 * OFFSET) - OFF_L;
    c = (g - ((n - 1) <<< (FRAC - 1))) * sp + $urandom_range(0, int'(sp - 1));
    return sat32(c);
  endfunction

  task automatic wait_idle();
    while (beat_q.size() != 0 || surf_q.size() != 0 || in_valid_i) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_SPACING) spacing_reg = data;
    else side_reg = data[7:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] sp, logic [15:0] sd, int budget);
    int k, stop_at;
    wait_idle();
    write_reg(CFG_SPACING, sp);
    write_reg(CFG_SIDE, sd);
    calm = ($urandom_range(0, 3) == 0);
    stop_at = items + budget;
    while (items < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 8) push_write(14'($urandom), pick_height());
      else if (k < 18) push_query(longint'($signed($urandom)), longint'($signed($urandom)));
      else push_query(pick_coord(), pick_coord());
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // ---------------- driver, receiver, monitor ----------------
  always @(posedge clk_i) in_taken <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold the beat
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid_i <= 1'b0;
      end else if (beat_q.size() != 0) begin
        action_i       <= beat_q[0].act;
        coord_x_i      <= beat_q[0].cx;
        coord_z_i      <= beat_q[0].cz;
        entry_index_i  <= beat_q[0].idx;
        entry_height_i <= beat_q[0].hv;
        in_valid_i     <= 1'b1;
        void'(beat_q.pop_front());
        if (calm) gap <= 0;
        else gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      end else begin
        in_valid_i <= 1'b0;
      end
      if (calm) out_ready_i <= 1'b1;
      else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_ready_i <= ~out_ready_i;
      else out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    surf_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (surf_q.size() == 0) begin
        report_mismatch("unexpected beat, height", surface_height_o, 0);
      end else begin
        e = surf_q.pop_front();
        if (out_of_bounds_o !== e.oob) report_mismatch("out_of_bounds", out_of_bounds_o, e.oob);
        if (surface_height_o !== e.h) report_mismatch("surface_height", surface_height_o, e.h);
        if (normal_x_o !== e.nx) report_mismatch("normal_x", normal_x_o, e.nx);
        if (normal_y_o !== e.ny) report_mismatch("normal_y", normal_y_o, e.ny);
        if (normal_z_o !== e.nz) report_mismatch("normal_z", normal_z_o, e.nz);
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    longint half;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_WRITE;
    coord_x_i = '0;
    coord_z_i = '0;
    entry_index_i = '0;
    entry_height_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SPACING;
    cfg_data_i = '0;
    errors = 0;
    items = 0;
    cycles = 0;
    calm = 1'b0;
    in_taken = 1'b0;
    gap = 0;
    spacing_reg = 16'd1;
    side_reg = 8'd128;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults after reset: unit spacing, full grid
    half = longint'(MAX_SIDE - 1) <<< (FRAC - 1);
    push_write(14'd0, 32'sh80000000);
    push_write(14'd16383, 32'sh7fffffff);
    push_write(14'd8127, 32'sh7fffffff);
    push_write(14'd8128, 32'sh80000000);
    push_write(14'd8255, 32'sh80000000);
    push_write(14'd8256, 32'sh7fffffff);
    push_query(0, 0);            // on the diagonal of the cell
    push_query(1, 0);            // upper triangle
    push_query(-1, 0);           // lower triangle
    push_query(-half, 0);        // on the low edge
    push_query(-half + 1, 0);
    push_query(half, 0);         // on the high edge
    push_query(half - 1, half - 1);
    push_query(-half + 1, -half + 1);
    push_query(I32_MIN, I32_MAX);
    push_query(I32_MAX, I32_MIN);
    push_query(0, -half + OFF_L + 1);
    push_query(100000, -200000);

    run_phase(16'd0, 16'd2, 150);
    run_phase(16'd65535, 16'd128, 250);
    run_phase(16'd3, {8'hA5, 8'd1}, 200);
    run_phase(16'd1, {8'h5A, 8'd200}, 250);
    for (int p = 0; p < 4; p++)
      run_phase(16'($urandom_range(1, 40)),
                {8'($urandom_range(0, 255)), 8'($urandom_range(2, 16))}, 270);

    wait_idle();
    repeat (200) @(negedge clk_i);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> sim.f
hdl/hmtq_pkg.sv
hdl/hmtq_grid_div.sv
hdl/hmtq_sampler.sv
hdl/hmtq_normal.sv
hdl/heightmap_triangle_height_query.sv
tb/sv/testbench.sv
